### sv/ncw_pkg.sv
`timescale 1ns / 1ps

package ncw_pkg;

    // Default number of pattern bits the block is built for
    localparam int PATTERN_BITS_DEF = 32;

    // Width of the width_in_use register and its reset value
    localparam int          CFG_BITS    = 6;
    localparam logic [5:0]  WIDTH_RESET = 6'd32;

    // Widest pattern the population count handles
    localparam int POP_BITS = 64;

    // Field masks for the six adder levels of the population count
    localparam logic [63:0] POP_MASK [6] = '{
        64'h5555_5555_5555_5555,
        64'h3333_3333_3333_3333,
        64'h0F0F_0F0F_0F0F_0F0F,
        64'h00FF_00FF_00FF_00FF,
        64'h0000_FFFF_0000_FFFF,
        64'h0000_0000_FFFF_FFFF
    };

    // Number of ones in a 64-bit word, six levels of pairwise field adds
    function automatic logic [6:0] f_popcount64(input logic [63:0] v);
        logic [63:0] acc;
        acc = v;
        for (int lvl = 0; lvl < 6; lvl++) begin
            acc = (acc & POP_MASK[lvl]) + ((acc >> (1 << lvl)) & POP_MASK[lvl]);
        end
        return acc[6:0];
    endfunction

endpackage

### sv/ncw_core.sv
`timescale 1ns / 1ps

module ncw_core #(
    parameter int W = ncw_pkg::PATTERN_BITS_DEF
) (
    input  logic [W-1:0]                 i_pattern,
    input  logic [ncw_pkg::CFG_BITS-1:0] i_width,
    output logic [W-1:0]                 o_next_pattern,
    output logic                         o_more
);
    import ncw_pkg::*;

    localparam int IDXW = (W > 1) ? $clog2(W) : 1;
    localparam int CNTW = $clog2(W + 1);
    localparam int SW   = CNTW + 1;

    logic [CNTW-1:0] width_eff;
    logic [W-1:0]    mask;
    logic [W-1:0]    p;
    logic [W-1:0]    hi_oh;      // highest one of p
    logic            top_set;    // p has its one at bit n-1
    logic [W-1:0]    pairs;      // "1 then 0" positions below n-1
    logic [W-1:0]    pair_oh;    // highest such pair
    logic            pair_any;
    logic [IDXW-1:0] ip;
    logic [W-1:0]    below_ip;
    logic [W-1:0]    keep;
    logic [SW-1:0]   cnt;
    logic [SW-1:0]   lo;
    logic [SW-1:0]   k;
    logic [SW-1:0]   hi_end;
    logic [W-1:0]    packed_bits;
    logic [W-1:0]    nxt;

    // n saturates at the built width
    assign width_eff = (32'(i_width) > 32'(W)) ? CNTW'(W) : CNTW'(i_width);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            mask[i] = (CNTW'(i) < width_eff);
        end
    end

    assign p       = i_pattern & mask;
    assign top_set = |(p & ~(mask >> 1));
    assign pairs   = p & ~(p >> 1) & (mask >> 1);
    assign pair_any = |pairs;

    always_comb begin
        for (int i = 0; i < W; i++) begin
            hi_oh[i]    = p[i] & ((p >> (i + 1)) == '0);
            pair_oh[i]  = pairs[i] & ((pairs >> (i + 1)) == '0);
            below_ip[i] = ((pair_oh >> (i + 1)) != '0);
        end
    end

    always_comb begin
        ip = '0;
        for (int i = 0; i < W; i++) begin
            if (pair_oh[i]) begin
                ip = ip | IDXW'(i);
            end
        end
    end

    // Ones at and above the pair get packed right after it; without a pair
    // the next weight starts packed from bit 0 with one extra one.
    assign keep   = pair_any ? ~below_ip : '1;
    assign cnt    = SW'(f_popcount64(POP_BITS'(p & keep)));
    assign lo     = pair_any ? SW'(ip) + SW'(1) : '0;
    assign k      = pair_any ? cnt : cnt + SW'(1);
    assign hi_end = lo + k;

    always_comb begin
        for (int i = 0; i < W; i++) begin
            packed_bits[i] = (SW'(i) >= lo) && (SW'(i) < hi_end);
        end
    end

    always_comb begin
        o_more = 1'b1;
        if (p == mask) begin
            nxt    = p;
            o_more = 1'b0;
        end else if (p == '0) begin
            nxt = W'(1);
        end else if (!top_set) begin
            nxt = p ^ hi_oh ^ (hi_oh << 1);
        end else begin
            nxt = (pair_any ? (p & below_ip) : '0) | packed_bits;
        end
    end

    assign o_next_pattern = nxt & mask;

endmodule

### sv/next_combination_by_weight.sv
`timescale 1ns / 1ps

// Next combination in order of increasing weight.
//
// Input channel: i_valid / o_stall carry one pattern beat on i_pattern.
// Output channel: o_valid / i_stall carry one result beat, o_next_pattern
// and o_more. A beat moves on an edge where valid is high and stall low.
// Config: i_cfg_we writes i_cfg_wdata into width_in_use (n); write it only
// while no beat is in flight.
// An accepted input beat goes through one input register, then the
// next-pattern logic into the result register. Throughput is one beat
// per cycle while the receiver does not stall, set by that single pass.
// When the receiver stalls, the result register holds and the input
// register keeps taking a beat until it too is full; o_stall then rises
// in the same cycle.
// Synchronous active-low reset empties both stages and sets n to 32.
module next_combination_by_weight #(
    parameter int PATTERN_BITS = ncw_pkg::PATTERN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ncw_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [PATTERN_BITS-1:0]       i_pattern,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [PATTERN_BITS-1:0]       o_next_pattern,
    output logic                          o_more
);
    import ncw_pkg::*;

    logic [CFG_BITS-1:0]     r_width;
    logic                    r_in_valid;
    logic [PATTERN_BITS-1:0] r_pattern;
    logic                    r_out_valid;
    logic [PATTERN_BITS-1:0] r_next;
    logic                    r_more;

    logic [PATTERN_BITS-1:0] n_next;
    logic                    n_more;
    logic                    out_adv;   // result register may load
    logic                    in_adv;    // input register may load

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    // Width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_pattern <= i_pattern;
        end
    end

    ncw_core #(
        .W (PATTERN_BITS)
    ) u_core (
        .i_pattern      (r_pattern),
        .i_width        (r_width),
        .o_next_pattern (n_next),
        .o_more         (n_more)
    );

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_next <= n_next;
            r_more <= n_more;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_pattern = r_next;
    assign o_more         = r_more;

    // A pending input beat always reaches the result stage once it frees up
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_adv |=> r_out_valid)
        else $error("input beat lost on its way to the result stage");

    // Upstream never sees stall while the result stage is empty
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("stall raised with empty result stage");

    // A produced combination with o_more set is never empty
    a_more_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_more |-> r_next != '0)
        else $error("next combination is all zeros");

    // Exhausted result with a nonzero width keeps bit 0 set (all ones)
    a_done_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_more && r_width != '0 |-> r_next[0])
        else $error("final combination is not all ones");

endmodule
